@@ rtl/sorted_record_table_top_assert.svh @@
// Assertion macros for the sorted record table.
`ifndef SORTED_RECORD_TABLE_TOP_ASSERT_SVH
`define SORTED_RECORD_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define SRT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define SRT_ASSERT(lbl, prop, msg)
`define SRT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/srt_pkg.sv @@
// Shared constants, codes and types for the sorted record table.
package srt_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int SCORE_W  = 24;
    localparam int REQ_W    = 2;
    localparam int IDX_W    = 6;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = KEY_W + SCORE_W;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_READ_WAIT,
        S_RESP
    } srt_state_t;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic signed [KEY_W-1:0]   rec_key;
        logic signed [SCORE_W-1:0] rec_score;
        logic [IDX_W-1:0]          read_index;
    } srt_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [CNT_W-1:0]          entry_count;
        logic signed [KEY_W-1:0]   out_key;
        logic signed [SCORE_W-1:0] out_score;
    } srt_result_t;

endpackage

@@ rtl/sorted_record_table_top.sv @@
// Sorted record table: top level with request channel and registered result channel.
//
// Keeps up to 64 (key, score) records in ascending key order in one RAM.
// Request channel s_*: req_type 0 insert, 1 delete by key, 2 read at index.
// Result channel m_*: status, entry count after the request, read key and
// score (zero unless a read succeeds). One result per request, in order.
// A transaction completes when valid and ready are both high.
// Requests are handled one at a time; the RAM has one read and one write
// port with a registered read, and every scan or shift step is a read
// followed by a compare or a write back.
// Full, empty, out-of-range or unused-code requests go straight to the result.
// A new request is taken once the previous result has been handed to the
// output register, even if the receiver has not yet taken it.
// When the receiver stalls, the result holds and the sequencer waits with
// the next result until the output register is free.
// Reset (aresetn low, synchronous) empties the table; RAM contents are
// left as they are and only slots below the count are ever used.
module sorted_record_table_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [srt_pkg::REQ_W-1:0]           s_req_type,
    input  logic signed [srt_pkg::KEY_W-1:0]    s_rec_key,
    input  logic signed [srt_pkg::SCORE_W-1:0]  s_rec_score,
    input  logic [srt_pkg::IDX_W-1:0]           s_read_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [srt_pkg::STATUS_W-1:0]        m_status,
    output logic [srt_pkg::CNT_W-1:0]           m_entry_count,
    output logic signed [srt_pkg::KEY_W-1:0]    m_out_key,
    output logic signed [srt_pkg::SCORE_W-1:0]  m_out_score
);

    srt_pkg::srt_req_t    req;
    srt_pkg::srt_result_t res;
    srt_pkg::srt_result_t m_data_reg;
    logic                 res_valid;
    logic                 res_ready;
    logic                 m_valid_reg;

    assign req.req_type   = s_req_type;
    assign req.rec_key    = s_rec_key;
    assign req.rec_score  = s_rec_score;
    assign req.read_index = s_read_index;

    srt_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_data_reg.status;
    assign m_entry_count = m_data_reg.entry_count;
    assign m_out_key     = m_data_reg.out_key;
    assign m_out_score   = m_data_reg.out_score;

endmodule

@@ rtl/srt_engine.sv @@
// Request sequencer and record memory: scan, shift and read over one RAM.
module srt_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    output logic                req_ready,
    input  srt_pkg::srt_req_t   req,
    output logic                res_valid,
    input  logic                res_ready,
    output srt_pkg::srt_result_t res
);

`include "sorted_record_table_top_assert.svh"

    srt_pkg::srt_state_t state_reg, state_next;

    logic [srt_pkg::REQ_W-1:0]          op_reg;
    logic signed [srt_pkg::KEY_W-1:0]   key_reg;
    logic signed [srt_pkg::SCORE_W-1:0] score_reg;
    logic [srt_pkg::CNT_W-1:0]          idx_reg;
    logic [srt_pkg::CNT_W-1:0]          pos_reg;
    logic [srt_pkg::CNT_W-1:0]          count_reg;
    logic [srt_pkg::STATUS_W-1:0]       status_reg;
    logic signed [srt_pkg::KEY_W-1:0]   out_key_reg;
    logic signed [srt_pkg::SCORE_W-1:0] out_score_reg;

    logic [srt_pkg::ENTRY_W-1:0] mem [srt_pkg::CAPACITY];
    logic [srt_pkg::ENTRY_W-1:0] rd_data_reg;
    logic [srt_pkg::ADDR_W-1:0]  rd_addr;
    logic [srt_pkg::ADDR_W-1:0]  wr_addr;
    logic [srt_pkg::ENTRY_W-1:0] wr_data;
    logic                        wr_en;

    logic signed [srt_pkg::KEY_W-1:0]   rd_key;
    logic signed [srt_pkg::SCORE_W-1:0] rd_score;
    logic [srt_pkg::CNT_W-1:0]          idx_inc;
    logic [srt_pkg::CNT_W-1:0]          idx_dec;
    logic [srt_pkg::CNT_W-1:0]          req_idx;
    logic                               key_lt;
    logic                               key_eq;
    logic                               is_full;

    assign rd_key   = $signed(rd_data_reg[srt_pkg::ENTRY_W-1:srt_pkg::SCORE_W]);
    assign rd_score = $signed(rd_data_reg[srt_pkg::SCORE_W-1:0]);
    assign idx_inc  = srt_pkg::CNT_W'(idx_reg + 1'b1);
    assign idx_dec  = srt_pkg::CNT_W'(idx_reg - 1'b1);
    assign req_idx  = srt_pkg::CNT_W'(req.read_index);
    assign key_lt   = rd_key < key_reg;
    assign key_eq   = rd_key == key_reg;
    assign is_full  = count_reg >= srt_pkg::CNT_W'(srt_pkg::CAPACITY);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srt_pkg::S_IDLE: begin
                if (req_valid) begin
                    case (req.req_type)
                        srt_pkg::REQ_INSERT:
                            state_next = is_full ? srt_pkg::S_RESP : srt_pkg::S_SCAN_RD;
                        srt_pkg::REQ_DELETE:
                            state_next = (count_reg == '0) ? srt_pkg::S_RESP
                                                           : srt_pkg::S_SCAN_RD;
                        srt_pkg::REQ_READ:
                            state_next = (req_idx >= count_reg) ? srt_pkg::S_RESP
                                                                : srt_pkg::S_READ_WAIT;
                        default: state_next = srt_pkg::S_RESP;
                    endcase
                end
            end
            srt_pkg::S_SCAN_RD: begin
                if (idx_reg == count_reg) begin
                    state_next = (op_reg == srt_pkg::REQ_INSERT) ? srt_pkg::S_INS_RD
                                                                  : srt_pkg::S_RESP;
                end else begin
                    state_next = srt_pkg::S_SCAN_CMP;
                end
            end
            srt_pkg::S_SCAN_CMP: begin
                if (op_reg == srt_pkg::REQ_INSERT) begin
                    state_next = key_lt ? srt_pkg::S_SCAN_RD : srt_pkg::S_INS_RD;
                end else begin
                    state_next = key_eq ? srt_pkg::S_DEL_RD : srt_pkg::S_SCAN_RD;
                end
            end
            srt_pkg::S_INS_RD:
                state_next = (idx_reg == pos_reg) ? srt_pkg::S_RESP : srt_pkg::S_INS_WR;
            srt_pkg::S_INS_WR:    state_next = srt_pkg::S_INS_RD;
            srt_pkg::S_DEL_RD:
                state_next = (idx_inc >= count_reg) ? srt_pkg::S_RESP : srt_pkg::S_DEL_WR;
            srt_pkg::S_DEL_WR:    state_next = srt_pkg::S_DEL_RD;
            srt_pkg::S_READ_WAIT: state_next = srt_pkg::S_RESP;
            srt_pkg::S_RESP: begin
                if (res_ready) begin
                    state_next = srt_pkg::S_IDLE;
                end
            end
            default: state_next = srt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        req_ready = state_reg == srt_pkg::S_IDLE;
        res_valid = state_reg == srt_pkg::S_RESP;
        rd_addr   = idx_reg[srt_pkg::ADDR_W-1:0];
        wr_en     = 1'b0;
        wr_addr   = idx_reg[srt_pkg::ADDR_W-1:0];
        wr_data   = rd_data_reg;
        case (state_reg)
            srt_pkg::S_IDLE:   rd_addr = req_idx[srt_pkg::ADDR_W-1:0];
            srt_pkg::S_INS_RD: begin
                rd_addr = idx_dec[srt_pkg::ADDR_W-1:0];
                if (idx_reg == pos_reg) begin
                    wr_en   = 1'b1;
                    wr_data = {key_reg, score_reg};
                end
            end
            srt_pkg::S_INS_WR: wr_en = 1'b1;
            srt_pkg::S_DEL_RD: rd_addr = idx_inc[srt_pkg::ADDR_W-1:0];
            srt_pkg::S_DEL_WR: wr_en = 1'b1;
            default: ;
        endcase
        res.status      = status_reg;
        res.entry_count = count_reg;
        res.out_key     = out_key_reg;
        res.out_score   = out_score_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srt_pkg::S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                srt_pkg::S_INS_RD: begin
                    if (idx_reg == pos_reg) begin
                        count_reg <= srt_pkg::CNT_W'(count_reg + 1'b1);
                    end
                end
                srt_pkg::S_DEL_RD: begin
                    if (idx_inc >= count_reg) begin
                        count_reg <= srt_pkg::CNT_W'(count_reg - 1'b1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            srt_pkg::S_IDLE: begin
                if (req_valid) begin
                    op_reg        <= req.req_type;
                    key_reg       <= req.rec_key;
                    score_reg     <= req.rec_score;
                    idx_reg       <= '0;
                    out_key_reg   <= '0;
                    out_score_reg <= '0;
                    status_reg    <= srt_pkg::ST_OK;
                    case (req.req_type)
                        srt_pkg::REQ_INSERT: begin
                            if (is_full) begin
                                status_reg <= srt_pkg::ST_FULL;
                            end
                        end
                        srt_pkg::REQ_DELETE: begin
                            if (count_reg == '0) begin
                                status_reg <= srt_pkg::ST_EMPTY;
                            end
                        end
                        srt_pkg::REQ_READ: begin
                            if (req_idx >= count_reg) begin
                                status_reg <= srt_pkg::ST_BAD_INDEX;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            srt_pkg::S_SCAN_RD: begin
                if (idx_reg == count_reg) begin
                    if (op_reg == srt_pkg::REQ_INSERT) begin
                        pos_reg <= idx_reg;
                    end else begin
                        status_reg <= srt_pkg::ST_NOT_FOUND;
                    end
                end
            end
            srt_pkg::S_SCAN_CMP: begin
                if (op_reg == srt_pkg::REQ_INSERT) begin
                    if (key_lt) begin
                        idx_reg <= idx_inc;
                    end else begin
                        pos_reg <= idx_reg;
                        idx_reg <= count_reg;
                    end
                end else if (!key_eq) begin
                    idx_reg <= idx_inc;
                end
            end
            srt_pkg::S_INS_WR: idx_reg <= idx_dec;
            srt_pkg::S_DEL_WR: idx_reg <= idx_inc;
            srt_pkg::S_READ_WAIT: begin
                out_key_reg   <= rd_key;
                out_score_reg <= rd_score;
            end
            default: ;
        endcase
    end

    `SRT_ASSERT(a_count_bound, count_reg <= srt_pkg::CNT_W'(srt_pkg::CAPACITY), "count above capacity")
    `SRT_ASSERT(a_ins_shift, state_reg == srt_pkg::S_INS_WR |-> idx_reg > pos_reg, "insert shift past slot")
    `SRT_ASSERT(a_del_shift, state_reg == srt_pkg::S_DEL_WR |-> idx_inc < count_reg, "delete shift past end")
    `SRT_ASSERT(a_full_count, res_valid && res.status == srt_pkg::ST_FULL |-> is_full, "full status without full table")
    `SRT_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> state_reg == srt_pkg::S_IDLE, "not idle after reset")

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the sorted record table: directed and random requests.
module tb;

    localparam logic [srt_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 1930;
    localparam int unsigned PHASE_LEN    = 120;
    localparam int unsigned STALL_LIMIT  = 6000;
    localparam int unsigned DRAIN_CYCLES = 300;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } load_mode_t;

    class record_table_shadow;
        logic signed [srt_pkg::KEY_W-1:0]   keys [srt_pkg::CAPACITY];
        logic signed [srt_pkg::SCORE_W-1:0] scores [srt_pkg::CAPACITY];
        int unsigned                        held;
        srt_pkg::srt_result_t               replies_due [$];
        int unsigned                        mismatches;
        int unsigned                        replies_seen;

        function new();
            held = 0;
            mismatches = 0;
            replies_seen = 0;
        endfunction

        function int unsigned owed();
            return replies_due.size();
        endfunction

        function void note_request(input srt_pkg::srt_req_t r);
            srt_pkg::srt_result_t reply;
            int unsigned pos;
            int unsigned i;
            reply = '0;
            case (r.req_type)
                srt_pkg::REQ_INSERT: begin
                    if (held >= srt_pkg::CAPACITY) begin
                        reply.status = srt_pkg::ST_FULL;
                    end else begin
                        pos = 0;
                        while (pos < held && $signed(keys[pos]) < $signed(r.rec_key)) pos++;
                        for (i = held; i > pos; i--) begin
                            keys[i]   = keys[i-1];
                            scores[i] = scores[i-1];
                        end
                        keys[pos]   = r.rec_key;
                        scores[pos] = r.rec_score;
                        held++;
                    end
                end
                srt_pkg::REQ_DELETE: begin
                    if (held == 0) begin
                        reply.status = srt_pkg::ST_EMPTY;
                    end else begin
                        pos = 0;
                        while (pos < held && keys[pos] != r.rec_key) pos++;
                        if (pos >= held) begin
                            reply.status = srt_pkg::ST_NOT_FOUND;
                        end else begin
                            for (i = pos; i + 1 < held; i++) begin
                                keys[i]   = keys[i+1];
                                scores[i] = scores[i+1];
                            end
                            held--;
                        end
                    end
                end
                srt_pkg::REQ_READ: begin
                    if (r.read_index >= held) begin
                        reply.status = srt_pkg::ST_BAD_INDEX;
                    end else begin
                        reply.out_key   = keys[r.read_index];
                        reply.out_score = scores[r.read_index];
                    end
                end
                default: ;
            endcase
            reply.entry_count = srt_pkg::CNT_W'(held);
            replies_due.push_back(reply);
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            $display("[%0t] mismatch on result %0d: %s", $time, replies_seen, what);
        endtask

        task check_result(input srt_pkg::srt_result_t got);
            srt_pkg::srt_result_t want;
            replies_seen++;
            if (replies_due.size() == 0) begin
                report_mismatch($sformatf("no request outstanding, got %p", got));
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.entry_count !== want.entry_count)
                report_mismatch($sformatf("count %0d, want %0d",
                                          got.entry_count, want.entry_count));
            if (got.out_key !== want.out_key)
                report_mismatch($sformatf("key %0d, want %0d",
                                          $signed(got.out_key), $signed(want.out_key)));
            if (got.out_score !== want.out_score)
                report_mismatch($sformatf("score %0d, want %0d",
                                          $signed(got.out_score), $signed(want.out_score)));
        endtask
    endclass

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [srt_pkg::REQ_W-1:0]           s_req_type = '0;
    logic signed [srt_pkg::KEY_W-1:0]    s_rec_key = '0;
    logic signed [srt_pkg::SCORE_W-1:0]  s_rec_score = '0;
    logic [srt_pkg::IDX_W-1:0]           s_read_index = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [srt_pkg::STATUS_W-1:0]        m_status;
    logic [srt_pkg::CNT_W-1:0]           m_entry_count;
    logic signed [srt_pkg::KEY_W-1:0]    m_out_key;
    logic signed [srt_pkg::SCORE_W-1:0]  m_out_score;

    record_table_shadow shadow = new();
    int unsigned        quiet_cycles = 0;

    always #10 aclk = ~aclk;

    sorted_record_table_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_rec_key     (s_rec_key),
        .s_rec_score   (s_rec_score),
        .s_read_index  (s_read_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .m_out_key     (m_out_key),
        .m_out_score   (m_out_score)
    );

    function automatic srt_pkg::srt_req_t make_request(
            input logic [srt_pkg::REQ_W-1:0] kind,
            input logic signed [srt_pkg::KEY_W-1:0] key,
            input logic signed [srt_pkg::SCORE_W-1:0] score,
            input logic [srt_pkg::IDX_W-1:0] idx);
        srt_pkg::srt_req_t r;
        r.req_type   = kind;
        r.rec_key    = key;
        r.rec_score  = score;
        r.read_index = idx;
        return r;
    endfunction

    function automatic logic signed [srt_pkg::KEY_W-1:0] pick_key();
        int unsigned sel;
        int          k;
        sel = $urandom_range(99);
        if (sel < 40) begin
            k = int'($urandom_range(6)) - 3;
        end else if (sel < 52) begin
            case ($urandom_range(3))
                0: k = 32'h8000_0000;
                1: k = 32'h7fff_ffff;
                2: k = 0;
                default: k = -1;
            endcase
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    function automatic logic signed [srt_pkg::SCORE_W-1:0] pick_score();
        if ($urandom_range(99) < 10) begin
            case ($urandom_range(3))
                0: return 24'h80_0000;
                1: return 24'h7f_ffff;
                2: return 24'h00_0000;
                default: return 24'hff_ffff;
            endcase
        end
        return srt_pkg::SCORE_W'($urandom);
    endfunction

    // Deletes mostly use held keys and reads mostly valid slots, to exercise deep shifts.
    function automatic srt_pkg::srt_req_t random_request(input load_mode_t mode);
        srt_pkg::srt_req_t r;
        int unsigned       roll;
        int unsigned       ins_pct;
        int unsigned       del_pct;
        r = make_request(srt_pkg::REQ_READ, pick_key(), pick_score(),
                         srt_pkg::IDX_W'($urandom));
        case (mode)
            MODE_FILL:  begin ins_pct = 75; del_pct = 8;  end
            MODE_DRAIN: begin ins_pct = 15; del_pct = 70; end
            default:    begin ins_pct = 35; del_pct = 30; end
        endcase
        roll = $urandom_range(99);
        if (roll < ins_pct) begin
            r.req_type = srt_pkg::REQ_INSERT;
        end else if (roll < ins_pct + del_pct) begin
            r.req_type = srt_pkg::REQ_DELETE;
            if (shadow.held != 0 && $urandom_range(99) < 75)
                r.rec_key = shadow.keys[$urandom_range(shadow.held - 1)];
        end else if (roll < 97) begin
            r.req_type = srt_pkg::REQ_READ;
            if (shadow.held != 0 && $urandom_range(99) < 80)
                r.read_index = srt_pkg::IDX_W'($urandom_range(shadow.held - 1));
        end else begin
            r.req_type = REQ_UNUSED;
        end
        return r;
    endfunction

    task automatic send_request(input srt_pkg::srt_req_t r, input bit may_idle);
        if (may_idle && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= r.req_type;
        s_rec_key    <= r.rec_key;
        s_rec_score  <= r.rec_score;
        s_read_index <= r.read_index;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        shadow.note_request(r);
    endtask

    // Result side: random back-pressure, one long hold-off, one stretch always ready.
    initial begin : result_sink
        int unsigned          hold_left;
        srt_pkg::srt_result_t got;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.status      = m_status;
                got.entry_count = m_entry_count;
                got.out_key     = m_out_key;
                got.out_score   = m_out_score;
                shadow.check_result(got);
                if (shadow.replies_seen == 400) hold_left = 500;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (shadow.replies_seen >= 900 && shadow.replies_seen < 1200) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 8);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : request_source
        srt_pkg::srt_req_t directed [$];
        load_mode_t        mode;
        int unsigned       n;
        int unsigned       phase;
        bit                may_idle;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, unused code, extremes, equal keys, bad index, absent key
        directed.push_back(make_request(srt_pkg::REQ_READ,   0, 0, 0));
        directed.push_back(make_request(srt_pkg::REQ_DELETE, 5, 0, 0));
        directed.push_back(make_request(REQ_UNUSED, -1, '1, '1));
        directed.push_back(make_request(srt_pkg::REQ_INSERT, 32'h7fff_ffff, 24'h7f_ffff, 0));
        directed.push_back(make_request(srt_pkg::REQ_INSERT, 32'h8000_0000, 24'h80_0000, 0));
        directed.push_back(make_request(srt_pkg::REQ_INSERT, 0, 0, 0));
        directed.push_back(make_request(srt_pkg::REQ_INSERT, 0, 1, 0));
        directed.push_back(make_request(srt_pkg::REQ_INSERT, -1, '1, 0));
        for (int i = 0; i < 5; i++)
            directed.push_back(make_request(srt_pkg::REQ_READ, 0, 0, srt_pkg::IDX_W'(i)));
        directed.push_back(make_request(srt_pkg::REQ_READ,   0, 0, 5));
        directed.push_back(make_request(srt_pkg::REQ_READ,   0, 0, '1));
        directed.push_back(make_request(srt_pkg::REQ_DELETE, 0, 0, 0));
        directed.push_back(make_request(srt_pkg::REQ_READ,   0, 0, 2));
        directed.push_back(make_request(srt_pkg::REQ_DELETE, 12345, 0, 0));
        directed.push_back(make_request(srt_pkg::REQ_DELETE, 32'h8000_0000, 0, 0));
        directed.push_back(make_request(srt_pkg::REQ_DELETE, 32'h7fff_ffff, 0, 0));
        directed.push_back(make_request(srt_pkg::REQ_DELETE, -1, 0, 0));
        directed.push_back(make_request(srt_pkg::REQ_DELETE, 0, 0, 0));
        directed.push_back(make_request(srt_pkg::REQ_READ,   0, 0, 0));
        foreach (directed[i])
            send_request(directed[i], 1'b1);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            phase = n / PHASE_LEN;
            if (n == 8 * PHASE_LEN) begin
                s_valid <= 1'b0;
                while (shadow.owed() != 0) @(posedge aclk);
            end
            case (phase % 5)
                0:       mode = MODE_FILL;
                2, 3:    mode = MODE_DRAIN;
                default: mode = MODE_MIXED;
            endcase
            may_idle = !(n >= 700 && n < 1000);
            send_request(random_request(mode), may_idle);
        end
        s_valid <= 1'b0;

        while (shadow.owed() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (shadow.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
